// ===== src/http_request_head_tokenizer_top_defines.svh =====
// ----------------------------------------------------------------------------
// http_request_head_tokenizer_top_defines.svh
// Assertion macros shared by the request head tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEAD_TOKENIZER_TOP_DEFINES_SVH
`define HTTP_REQUEST_HEAD_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hrt_pkg.sv =====
// ----------------------------------------------------------------------------
// hrt_pkg
// Types and constants for the HTTP request head tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrt_pkg;

    typedef enum logic [1:0] {
        PH_LINE,
        PH_KEY,
        PH_VALUE,
        PH_BODY
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } byte_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  byte_class;
        logic        closes_field;
        logic        head_done;
        logic [31:0] body_length;
        logic        method_is_get;
        logic        message_end;
        logic        request_bad;
        logic        line_malformed;
    } result_item_t;

    // byte classes
    localparam logic [2:0] CLS_DELIM   = 3'd0;
    localparam logic [2:0] CLS_METHOD  = 3'd1;
    localparam logic [2:0] CLS_URI     = 3'd2;
    localparam logic [2:0] CLS_VERSION = 3'd3;
    localparam logic [2:0] CLS_KEY     = 3'd4;
    localparam logic [2:0] CLS_VALUE   = 3'd5;
    localparam logic [2:0] CLS_BODY    = 3'd6;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam int unsigned GET_LEN = 3;
    localparam logic [1:0]  GET_DONE = 2'd3;
    localparam logic [7:0]  GET_LIT [GET_LEN] = '{8'h47, 8'h45, 8'h54};

    // "content-length", matched on lower-cased key bytes
    localparam int unsigned KEY_LEN  = 14;
    localparam logic [3:0]  KEY_DONE = 4'd14;
    localparam logic [3:0]  KEY_FAIL = 4'd15;
    localparam logic [7:0]  KEY_LIT [KEY_LEN] = '{
        8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,
        8'h2D, 8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68
    };

endpackage

`default_nettype wire

// ===== src/http_request_head_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// http_request_head_tokenizer_top
// Byte-wide HTTP/1.1 request head tokenizer with content-length tracking.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  -------   -------------------------  ---------------------------------
//  byte      byte_valid / byte_ready    byte_item   (hrt_pkg::byte_item_t)
//  result    result_valid/result_ready  result_item (hrt_pkg::result_item_t)
//
//  One byte per cycle while byte_ready is high; each byte yields one result, registered into the output queue.
//  The parser state updates in the same cycle the byte transfers; the length
//  multiply-accumulate (shift-add by ten) is the longest path.
//  Results sit in a two-entry output queue, so byte_ready only drops when both
//  entries are full; byte_ready is a register output.
//  Reset puts the parser at the start of a request line, queue empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "http_request_head_tokenizer_top_defines.svh"

module http_request_head_tokenizer_top
    import hrt_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         byte_valid,
    output logic              byte_ready,
    input  wire byte_item_t   byte_item,
    output logic              result_valid,
    input  wire logic         result_ready,
    output result_item_t      result_item
);

    localparam int unsigned PROD_BITS = LENGTH_BITS + 4;

    // parser state
    phase_t                 phase_reg,       phase_next;
    logic [1:0]             space_count_reg, space_count_next;
    logic                   pending_cr_reg,  pending_cr_next;
    logic                   line_empty_reg,  line_empty_next;
    logic [1:0]             get_idx_reg,     get_idx_next;
    logic                   is_get_reg,      is_get_next;
    logic [3:0]             key_idx_reg,     key_idx_next;
    logic                   key_is_len_reg,  key_is_len_next;
    logic [LENGTH_BITS-1:0] len_accum_reg,   len_accum_next;
    logic [LENGTH_BITS-1:0] body_rem_reg,    body_rem_next;

    // output queue
    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    result_item_t out_reg, out_next;
    result_item_t skid_reg, skid_next;

    result_item_t res;
    logic         push;
    logic         pop;

    logic [7:0]                  b;
    logic [7:0]                  lc;
    logic                        crlf;
    logic [3:0]                  digit;
    logic [PROD_BITS-1:0]        prod;
    logic [LENGTH_BITS-1:0]      body_dec;
    logic [LENGTH_BITS+31:0]     len_ext;

    assign push = byte_valid && byte_ready;
    assign pop  = out_valid_reg && result_ready;

    assign byte_ready   = !skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

    assign b     = byte_item.data_byte;
    assign lc    = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_OFS : b;
    assign crlf  = pending_cr_reg && (b == CH_LF);
    assign digit = 4'(b - CH_ZERO);
    assign prod  = {1'b0, len_accum_reg, 3'b000} + {3'b000, len_accum_reg, 1'b0}
                 + {{LENGTH_BITS{1'b0}}, digit};
    assign body_dec = body_rem_reg - {{(LENGTH_BITS-1){1'b0}}, (body_rem_reg != '0)};

    // next parser state and result for the byte on the input
    always_comb
    begin
        phase_next       = phase_reg;
        space_count_next = space_count_reg;
        pending_cr_next  = 1'b0;
        line_empty_next  = line_empty_reg;
        get_idx_next     = get_idx_reg;
        is_get_next      = is_get_reg;
        key_idx_next     = key_idx_reg;
        key_is_len_next  = key_is_len_reg;
        len_accum_next   = len_accum_reg;
        body_rem_next    = body_rem_reg;
        len_ext          = '0;

        res                = '0;
        res.out_byte       = b;
        res.byte_class     = CLS_DELIM;

        priority if (phase_reg == PH_BODY)
        begin
            res.byte_class   = CLS_BODY;
            body_rem_next    = body_dec;
            res.message_end  = (body_dec == '0);
        end
        else if (b == CH_CR)
        begin
            pending_cr_next = 1'b1;
        end
        else if (phase_reg == PH_LINE)
        begin
            priority if (crlf)
            begin
                res.closes_field = (space_count_reg >= 2'd2);
                phase_next       = PH_KEY;
                line_empty_next  = 1'b1;
                key_idx_next     = '0;
            end
            else if (b == CH_SPACE)
            begin
                res.closes_field   = (space_count_reg < 2'd2);
                res.line_malformed = (space_count_reg >= 2'd2);
                if (space_count_reg != 2'd3)
                begin
                    space_count_next = space_count_reg + 2'd1;
                end
                get_idx_next = GET_DONE;
            end
            else if (space_count_reg == 2'd0)
            begin
                res.byte_class = CLS_METHOD;
                if (get_idx_reg != GET_DONE)
                begin
                    if (b == GET_LIT[get_idx_reg])
                    begin
                        get_idx_next = get_idx_reg + 2'd1;
                        if (get_idx_reg == GET_DONE - 2'd1)
                        begin
                            is_get_next = 1'b1;
                        end
                    end
                    else
                    begin
                        get_idx_next = GET_DONE;
                    end
                end
            end
            else
            begin
                res.byte_class = (space_count_reg == 2'd1) ? CLS_URI : CLS_VERSION;
            end
        end
        else if (phase_reg == PH_KEY)
        begin
            priority if (crlf)
            begin
                if (line_empty_reg)
                begin
                    res.head_done = 1'b1;
                    if (len_accum_reg == '0)
                    begin
                        res.message_end = 1'b1;
                    end
                    else
                    begin
                        phase_next    = PH_BODY;
                        body_rem_next = len_accum_reg;
                    end
                end
                else
                begin
                    // key line with no colon: flag and drop it
                    res.line_malformed = 1'b1;
                    line_empty_next    = 1'b1;
                    key_idx_next       = '0;
                end
            end
            else if (b == CH_COLON)
            begin
                res.closes_field = 1'b1;
                line_empty_next  = 1'b0;
                key_is_len_next  = (key_idx_reg == KEY_DONE);
                if (key_idx_reg == KEY_DONE)
                begin
                    len_accum_next = '0;
                end
                key_idx_next = '0;
                phase_next   = PH_VALUE;
            end
            else
            begin
                res.byte_class  = CLS_KEY;
                line_empty_next = 1'b0;
                if (key_idx_reg < KEY_DONE)
                begin
                    key_idx_next = (lc == KEY_LIT[key_idx_reg]) ? key_idx_reg + 4'd1
                                                                : KEY_FAIL;
                end
            end
        end
        else
        begin
            if (crlf)
            begin
                res.closes_field = 1'b1;
                phase_next       = PH_KEY;
                line_empty_next  = 1'b1;
                key_idx_next     = '0;
                key_is_len_next  = 1'b0;
            end
            else
            begin
                res.byte_class = CLS_VALUE;
                if (key_is_len_reg)
                begin
                    if (b >= CH_ZERO && b <= CH_NINE)
                    begin
                        // saturate when ten times the value plus the digit overflows
                        len_accum_next = (prod[LENGTH_BITS +: 4] != 4'd0)
                                       ? '1 : prod[LENGTH_BITS-1:0];
                        key_idx_next   = 4'd1;
                    end
                    else if (!((b == CH_SPACE || b == CH_TAB) && key_idx_reg == 4'd0))
                    begin
                        key_is_len_next = 1'b0;
                    end
                end
            end
        end

        res.request_bad = byte_item.buffer_end && !is_get_next
                       && (phase_next != PH_BODY) && !res.head_done;

        len_ext           = {32'd0, len_accum_next};
        res.body_length   = len_ext[31:0];
        res.method_is_get = is_get_next;

        // rearm for the next request
        if (res.message_end)
        begin
            phase_next       = PH_LINE;
            space_count_next = '0;
            pending_cr_next  = 1'b0;
            line_empty_next  = 1'b1;
            get_idx_next     = '0;
            is_get_next      = 1'b0;
            key_idx_next     = '0;
            key_is_len_next  = 1'b0;
            len_accum_next   = '0;
            body_rem_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LINE;
            space_count_reg <= '0;
            pending_cr_reg  <= 1'b0;
            line_empty_reg  <= 1'b1;
            get_idx_reg     <= '0;
            is_get_reg      <= 1'b0;
            key_idx_reg     <= '0;
            key_is_len_reg  <= 1'b0;
            len_accum_reg   <= '0;
            body_rem_reg    <= '0;
        end
        else if (push)
        begin
            phase_reg       <= phase_next;
            space_count_reg <= space_count_next;
            pending_cr_reg  <= pending_cr_next;
            line_empty_reg  <= line_empty_next;
            get_idx_reg     <= get_idx_next;
            is_get_reg      <= is_get_next;
            key_idx_reg     <= key_idx_next;
            key_is_len_reg  <= key_is_len_next;
            len_accum_reg   <= len_accum_next;
            body_rem_reg    <= body_rem_next;
        end
    end

    // output queue: head entry drives the port, skid entry catches a stalled transfer
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = push;
                skid_next       = res;
            end
            else
            begin
                out_valid_next = push;
                out_next       = res;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = push;
            out_next       = res;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    `HRT_ASSERT_NOW(a_skid_behind_head, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid entry held while head entry empty")
    `HRT_ASSERT_NOW(a_head_done_on_lf, clk, rst_n, result_valid && result_item.head_done,
        result_item.out_byte == CH_LF, "head_done on a byte other than line feed")
    `HRT_ASSERT_NEXT(a_rearm_after_end, clk, rst_n, push && res.message_end,
        phase_reg == PH_LINE && len_accum_reg == '0 && !is_get_reg,
        "parser not rearmed after message end")
    `HRT_ASSERT_NOW(a_body_class_phase, clk, rst_n, push && res.byte_class == CLS_BODY,
        phase_reg == PH_BODY && body_rem_reg != '0, "body byte outside body phase")
    `HRT_ASSERT_NOW(a_bad_not_done, clk, rst_n, result_valid,
        !(result_item.request_bad && result_item.head_done),
        "request_bad raised on the head_done byte")

endmodule

`default_nettype wire

// ===== test/http_request_head_tokenizer_top_tb.sv =====
// ----------------------------------------------------------------------------
// http_request_head_tokenizer_top_tb
// Streams HTTP request bytes into the head tokenizer and checks every result
// against a cycle-free parser model kept in the bench. Directed requests hit
// the line-end, spacing, colon, content-length and buffer-end corner cases;
// random requests follow under three sender/receiver throttling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_request_head_tokenizer_top_tb;
    import hrt_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned BODY_CAP = 64;
    localparam int unsigned MAX_PRINTED = 60;
    localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;
    localparam logic [8*3-1:0] GET_TEXT = "GET";
    localparam logic [8*14-1:0] LENGTH_KEY = "content-length";
    localparam logic [1:0] GET_MATCHED = 2'd3;
    localparam logic [3:0] KEY_MATCHED = 4'd14;
    localparam logic [3:0] KEY_MISS = 4'd15;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic byte_ready;
    byte_item_t byte_item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_item_t result_item;

    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    result_item_t expected_results[$];
    result_item_t want_item;
    byte_item_t pending_bytes[$];

    // parser model state
    phase_t stage;
    logic [1:0] spaces;
    logic [1:0] get_idx;
    logic pend_cr;
    logic line_blank;
    logic saw_get;
    logic [3:0] key_idx;
    logic key_is_len;
    logic digits_seen;
    logic [31:0] len_accum;
    logic [31:0] body_left;

    http_request_head_tokenizer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void rearm_parser();
        stage = PH_LINE;
        spaces = '0;
        get_idx = '0;
        pend_cr = 1'b0;
        line_blank = 1'b1;
        saw_get = 1'b0;
        key_idx = '0;
        key_is_len = 1'b0;
        digits_seen = 1'b0;
        len_accum = '0;
        body_left = '0;
    endfunction

    // Advance the model by one byte and return the result it should produce.
    function automatic result_item_t parse_byte(byte_item_t item);
        result_item_t res;
        logic [7:0] b;
        logic [7:0] lc;
        logic crlf;
        logic [31:0] digit;
        b = item.data_byte;
        crlf = pend_cr && (b == CH_LF);
        res = '0;
        res.out_byte = b;
        res.byte_class = CLS_DELIM;
        pend_cr = 1'b0;
        if (stage == PH_BODY)
        begin
            res.byte_class = CLS_BODY;
            if (body_left != 0)
                body_left = body_left - 32'd1;
            if (body_left == 0)
                res.message_end = 1'b1;
        end
        else if (b == CH_CR)
        begin
            pend_cr = 1'b1;
        end
        else if (stage == PH_LINE)
        begin
            if (crlf)
            begin
                res.closes_field = (spaces >= 2);
                stage = PH_KEY;
                line_blank = 1'b1;
                key_idx = '0;
            end
            else if (b == CH_SPACE)
            begin
                res.closes_field = (spaces < 2);
                res.line_malformed = (spaces >= 2);
                if (spaces < 3)
                    spaces = spaces + 2'd1;
                get_idx = GET_MATCHED;
            end
            else if (spaces == 0)
            begin
                res.byte_class = CLS_METHOD;
                if (get_idx != GET_MATCHED)
                begin
                    if (b == GET_TEXT[8*(2 - int'(get_idx)) +: 8])
                    begin
                        get_idx = get_idx + 2'd1;
                        if (get_idx == GET_MATCHED)
                            saw_get = 1'b1;
                    end
                    else
                    begin
                        get_idx = GET_MATCHED;
                    end
                end
            end
            else
            begin
                res.byte_class = (spaces == 1) ? CLS_URI : CLS_VERSION;
            end
        end
        else if (stage == PH_KEY)
        begin
            if (crlf)
            begin
                if (line_blank)
                begin
                    res.head_done = 1'b1;
                    if (len_accum == 0)
                        res.message_end = 1'b1;
                    else
                    begin
                        stage = PH_BODY;
                        body_left = len_accum;
                    end
                end
                else
                begin
                    res.line_malformed = 1'b1;
                    line_blank = 1'b1;
                    key_idx = '0;
                end
            end
            else if (b == CH_COLON)
            begin
                res.closes_field = 1'b1;
                line_blank = 1'b0;
                key_is_len = (key_idx == KEY_MATCHED);
                if (key_is_len)
                    len_accum = '0;
                key_idx = '0;
                digits_seen = 1'b0;
                stage = PH_VALUE;
            end
            else
            begin
                lc = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_OFS : b;
                res.byte_class = CLS_KEY;
                line_blank = 1'b0;
                if (key_idx < KEY_MATCHED)
                begin
                    if (lc == LENGTH_KEY[8*(13 - int'(key_idx)) +: 8])
                        key_idx = key_idx + 4'd1;
                    else
                        key_idx = KEY_MISS;
                end
            end
        end
        else
        begin
            if (crlf)
            begin
                res.closes_field = 1'b1;
                stage = PH_KEY;
                line_blank = 1'b1;
                key_idx = '0;
                key_is_len = 1'b0;
            end
            else
            begin
                res.byte_class = CLS_VALUE;
                if (key_is_len)
                begin
                    if (b >= CH_ZERO && b <= CH_NINE)
                    begin
                        digit = 32'(b - CH_ZERO);
                        if (len_accum > (LEN_MAX - digit) / 10)
                            len_accum = LEN_MAX;
                        else
                            len_accum = len_accum * 10 + digit;
                        digits_seen = 1'b1;
                    end
                    // blanks ahead of the first digit are skipped
                    else if (!((b == CH_SPACE || b == CH_TAB) && !digits_seen))
                        key_is_len = 1'b0;
                end
            end
        end
        res.request_bad = item.buffer_end && !saw_get && stage != PH_BODY && !res.head_done;
        res.body_length = len_accum;
        res.method_is_get = saw_get;
        if (res.message_end)
            rearm_parser();
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        // keep the log short on a badly broken build
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                results_seen, name, got, want));
    endtask

    // Check each result transfer and throttle the result side.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result %0d with nothing expected", results_seen));
            else
            begin
                want_item = expected_results.pop_front();
                check_field("out_byte", result_item.out_byte, want_item.out_byte);
                check_field("byte_class", result_item.byte_class, want_item.byte_class);
                check_field("closes_field", result_item.closes_field, want_item.closes_field);
                check_field("head_done", result_item.head_done, want_item.head_done);
                check_field("body_length", result_item.body_length, want_item.body_length);
                check_field("method_is_get", result_item.method_is_get,
                    want_item.method_is_get);
                check_field("message_end", result_item.message_end, want_item.message_end);
                check_field("request_bad", result_item.request_bad, want_item.request_bad);
                check_field("line_malformed", result_item.line_malformed,
                    want_item.line_malformed);
            end
            results_seen++;
        end
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_byte(byte_item_t item);
        while ($urandom_range(99) < send_gap_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item <= item;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        expected_results.push_back(parse_byte(item));
        bytes_sent++;
    endtask

    task automatic push_byte(logic [7:0] b, logic bend);
        byte_item_t item;
        item.data_byte = b;
        item.buffer_end = bend;
        pending_bytes.push_back(item);
    endtask

    task automatic push_text(string s);
        foreach (s[i])
            push_byte(s[i], 1'b0);
    endtask

    task automatic push_line_end();
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
    endtask

    task automatic push_random(int unsigned min_n, int unsigned max_n,
                               logic [7:0] lo, logic [7:0] hi);
        logic [7:0] c;
        repeat ($urandom_range(max_n, min_n))
        begin
            c = 8'($urandom_range(hi, lo));
            // a stray CR could end the line early
            if (c == CH_CR)
                c = CH_LF;
            push_byte(c, 1'b0);
        end
    endtask

    task automatic send_pending(bit noisy_end);
        byte_item_t item;
        while (pending_bytes.size() != 0)
        begin
            item = pending_bytes.pop_front();
            if (noisy_end && $urandom_range(29) == 0)
                item.buffer_end = 1'b1;
            send_byte(item);
        end
    endtask

    // GET flag, third space, version extremes, CR CR LF line end
    task automatic test_request_line();
        push_text("GET / H ");
        push_byte(8'hFF, 1'b0);
        push_byte(CH_CR, 1'b0);
        push_line_end();
        send_pending(1'b0);
    endtask

    // bare LF and lone CR in a key, missing colon, mixed-case length, body
    task automatic test_header_lines();
        push_byte(CH_LF, 1'b0);
        push_byte(CH_CR, 1'b0);
        push_text("z");
        push_line_end();
        push_text("Content-LENGTH: ");
        push_byte(CH_TAB, 1'b0);
        push_text("2x9");
        push_line_end();
        push_line_end();
        push_byte(CH_CR, 1'b0);
        push_byte(8'h00, 1'b0);
        send_pending(1'b0);
    endtask

    // buffer end on non-GET and GET requests, zero-length message
    task automatic test_buffer_end();
        push_byte("P", 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b1);
        push_byte(CH_CR, 1'b1);
        push_byte(CH_LF, 1'b1);
        push_text("GE");
        push_byte("T", 1'b1);
        push_line_end();
        push_line_end();
        send_pending(1'b0);
    endtask

    task automatic test_random_traffic(int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned cut;
        int unsigned i;
        bit truncated;
        bit head_closed;
        logic [7:0] c;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(9);
            case (pick)
                0, 1, 2, 3: push_text("GET");
                4: push_text("POST");
                5: push_text("GE");
                6: push_text("get");
                7: push_text("GETS");
                default: push_random(1, 6, 8'h21, 8'h7E);
            endcase
            if ($urandom_range(19) != 0)
            begin
                push_byte(CH_SPACE, 1'b0);
                push_random(0, 8, 8'h21, 8'h7E);
                if ($urandom_range(19) != 0)
                begin
                    push_byte(CH_SPACE, 1'b0);
                    push_text(($urandom_range(3) != 0) ? "HTTP/1.1" : "HTTP/1.0");
                    if ($urandom_range(9) == 0)
                    begin
                        push_byte(CH_SPACE, 1'b0);
                        push_random(0, 3, 8'h21, 8'h7E);
                    end
                end
            end
            push_line_end();
            repeat ($urandom_range(4))
            begin
                pick = $urandom_range(9);
                if (pick < 4)
                begin
                    for (i = 0; i < 14; i++)
                    begin
                        c = LENGTH_KEY[8*(13 - i) +: 8];
                        if (c != "-" && $urandom_range(1) == 1)
                            c = c - CASE_OFS;
                        push_byte(c, 1'b0);
                    end
                    push_byte(CH_COLON, 1'b0);
                    repeat ($urandom_range(2))
                        push_byte(($urandom_range(1) == 1) ? CH_TAB : CH_SPACE, 1'b0);
                    if ($urandom_range(9) == 0)
                        push_random(10, 20, CH_ZERO, CH_NINE);
                    else
                        push_text($sformatf("%0d", $urandom_range(40)));
                    if ($urandom_range(7) == 0)
                        push_text("x7");
                end
                else if (pick < 6)
                begin
                    if (pick == 4)
                        push_random(1, 10, "a", "z");
                    else
                        push_text(($urandom_range(1) == 1) ? "content-len" : "content-lengths");
                    push_byte(CH_COLON, 1'b0);
                    push_random(0, 10, 8'h20, 8'h7E);
                    if ($urandom_range(7) == 0)
                    begin
                        push_byte(CH_CR, 1'b0);
                        push_text("q");
                    end
                end
                else if (pick < 8)
                    push_random(1, 12, 8'h00, 8'hFF);
                else
                    push_random(1, 8, "A", "Z");
                push_line_end();
            end
            truncated = ($urandom_range(9) == 0);
            if (truncated)
            begin
                cut = $urandom_range(pending_bytes.size() - 1, 1);
                pending_bytes = pending_bytes[0:cut-1];
                pending_bytes[cut-1].buffer_end = 1'b1;
            end
            send_pending(1'b1);
            if (!truncated)
            begin
                // close whatever line is open, then end the head with a sane length
                head_closed = 1'b0;
                while (!head_closed)
                begin
                    if (stage == PH_KEY && line_blank && len_accum > BODY_CAP)
                        push_text("content-length:5");
                    else if (stage == PH_KEY && line_blank)
                        head_closed = 1'b1;
                    push_line_end();
                    send_pending(1'b1);
                end
                while (stage == PH_BODY)
                begin
                    push_byte(8'($urandom_range(255)), 1'b0);
                    send_pending(1'b1);
                end
            end
        end
    endtask

    initial
    begin
        rearm_parser();
        send_gap_pct = 18;
        recv_stall_pct = 75;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_request_line();
        test_header_lines();
        test_buffer_end();
        test_random_traffic(530);

        send_gap_pct = 75;
        recv_stall_pct = 18;
        test_random_traffic(530);

        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random_traffic(540);

        byte_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
